[sv/assert_macros.svh]
// Assertion macros for the list unit; included by the datapath.
// Used by files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`endif
`endif

[sv/blwd_pkg.sv]
// Shared types and constants for the bounded list unit.
// No dependencies; imported by the controller, datapath and top level.
package blwd_pkg;

  localparam int VALUE_W  = 64;
  localparam int COUNT_W  = 6;
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 72;
  localparam int M_USER_W = 2;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_REMOVE_ALL = 2'd2,
    OP_DUMP       = 2'd3
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    op_t  op;
    logic rm_run;
    logic dump_run;
    logic send_status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rm_done;
    logic dump_done;
    logic out_free;
    logic empty;
  } sts_t;

endpackage

[sv/bounded_list_with_delete_all_unit.sv]
// Bounded ordered list unit: holds up to DEPTH signed 64-bit entries.
// Input stream (s_*): one word per command. s_tdata carries the operation
// (push front, push back, remove all equal, dump) and the operand value.
// Output stream (m_*): push and remove give one status word with the new
// count and flags; dump gives every entry head to tail with m_tlast on the
// final one, or one status word flagged empty when the list holds nothing.
// One command is worked at a time. A push passes through the status state
// to the output register. Remove walks the list at one entry per cycle,
// reading one entry and rewriting a kept one in the same cycle, then gives
// its status word. Dump streams one entry per cycle while the receiver
// keeps up, once its first memory read has returned.
// Reset (rst, synchronous) empties the list; memory contents are not cleared.
// A stalled receiver holds the output register and pauses the dump walk
// without losing or repeating entries; no new command is accepted until
// the current one has handed its last word to the output register.
module bounded_list_with_delete_all_unit #(
  parameter int DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [1:0] operation, [65:2] operand_value, [71:66] zero
  input  logic [blwd_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [63:0] entry_value, [69:64] entry_count, [71:70] zero
  output logic [blwd_pkg::M_DATA_W-1:0]  m_tdata,
  // [0] list_empty, [1] overflow
  output logic [blwd_pkg::M_USER_W-1:0]  m_tuser,
  output logic                           m_tlast
);
  import blwd_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  op_t                op;
  logic [VALUE_W-1:0] operand;
  logic [VALUE_W-1:0] out_entry;
  logic               out_empty;
  logic               out_ovf;
  logic [COUNT_W-1:0] out_count;

  assign op      = op_t'(s_tdata[1:0]);
  assign operand = s_tdata[VALUE_W+1:2];

  blwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (op),
    .sts      (sts),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  blwd_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .operand   (operand),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .out_entry (out_entry),
    .out_last  (m_tlast),
    .out_empty (out_empty),
    .out_ovf   (out_ovf),
    .out_count (out_count)
  );

  assign m_tdata = {{(M_DATA_W - VALUE_W - COUNT_W){1'b0}}, out_count, out_entry};
  assign m_tuser = {out_ovf, out_empty};

endmodule

[sv/blwd_ctrl.sv]
// Sequencer for the bounded list unit: takes one word, runs it, returns to idle.
// Depends on blwd_pkg for the command and status structs.
module blwd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  blwd_pkg::op_t  op,
  input  blwd_pkg::sts_t sts,
  output logic           s_tready,
  output blwd_pkg::cmd_t cmd
);
  import blwd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_REMOVE = 4'b0010,
    ST_DUMP   = 4'b0100,
    ST_STATUS = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd.accept      = accept;
    cmd.op          = op;
    cmd.rm_run      = (state == ST_REMOVE);
    cmd.dump_run    = (state == ST_DUMP);
    cmd.send_status = (state == ST_STATUS);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: state_next = ST_STATUS;
            OP_REMOVE_ALL:               state_next = ST_REMOVE;
            OP_DUMP:                     state_next = sts.empty ? ST_STATUS : ST_DUMP;
            default:                     state_next = ST_IDLE;
          endcase
        end
      end
      ST_REMOVE: if (sts.rm_done) state_next = ST_STATUS;
      ST_DUMP:   if (sts.dump_done) state_next = ST_IDLE;
      ST_STATUS: if (sts.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/blwd_dp.sv]
// Datapath of the bounded list unit: circular entry memory, head and count,
// walk pointers for remove and dump, and the output register.
// Depends on blwd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module blwd_dp #(
  parameter int DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  blwd_pkg::cmd_t                cmd,
  input  logic [blwd_pkg::VALUE_W-1:0]  operand,
  output blwd_pkg::sts_t                sts,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [blwd_pkg::VALUE_W-1:0]  out_entry,
  output logic                          out_last,
  output logic                          out_empty,
  output logic                          out_ovf,
  output logic [blwd_pkg::COUNT_W-1:0]  out_count
);
  import blwd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [PW:0]   DEPTH_S = (PW + 1)'(DEPTH);
  localparam logic [PW-1:0] LAST_POS = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata;
  logic [VALUE_W-1:0] key;

  logic [PW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] wr_idx, wr_idx_next;
  logic          ovf;
  logic          cmp_valid, cmp_valid_next;
  logic          rd_valid, rd_valid_next;
  logic          rd_last, rd_last_next;

  logic               rd_en, wr_en;
  logic [PW-1:0]      rd_addr, wr_addr;
  logic [VALUE_W-1:0] wr_data;

  logic full, out_free, ent_load, status_load, issue, is_push;
  logic [XW-1:0] count_x;

  function automatic logic [PW-1:0] phys(input logic [PW-1:0] base,
                                         input logic [PW-1:0] off);
    logic [PW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_S) sum = sum - DEPTH_S;
    return sum[PW-1:0];
  endfunction

  assign full        = (count == DEPTH_C);
  assign out_free    = !m_tvalid || m_tready;
  assign ent_load    = cmd.dump_run && rd_valid && out_free;
  assign status_load = cmd.send_status && out_free;
  assign is_push     = (cmd.op == OP_PUSH_FRONT) || (cmd.op == OP_PUSH_BACK);
  assign issue       = cmd.dump_run && (idx != count) && (!rd_valid || ent_load);
  assign count_x     = XW'(count);

  always_comb begin
    sts.rm_done   = (idx == count) && !cmp_valid;
    sts.dump_done = (idx == count) && !rd_valid;
    sts.out_free  = out_free;
    sts.empty     = (count == '0);
  end

  always_comb begin
    head_next      = head;
    count_next     = count;
    idx_next       = idx;
    wr_idx_next    = wr_idx;
    cmp_valid_next = 1'b0;
    rd_valid_next  = rd_valid;
    rd_last_next   = rd_last;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = rdata;

    if (cmd.accept) begin
      idx_next      = '0;
      wr_idx_next   = '0;
      rd_valid_next = 1'b0;
      if (is_push && !full) begin
        wr_en      = 1'b1;
        wr_data    = operand;
        count_next = count + CW'(1);
        if (cmd.op == OP_PUSH_FRONT) begin
          head_next = (head == '0) ? LAST_POS : head - PW'(1);
          wr_addr   = head_next;
        end else begin
          wr_addr = phys(head, count[PW-1:0]);
        end
      end
    end

    // Compact in place: keep entries that differ from the key
    if (cmd.rm_run) begin
      if (idx != count) begin
        rd_en          = 1'b1;
        rd_addr        = phys(head, idx[PW-1:0]);
        idx_next       = idx + CW'(1);
        cmp_valid_next = 1'b1;
      end
      if (cmp_valid && (rdata != key)) begin
        wr_en       = 1'b1;
        wr_addr     = phys(head, wr_idx[PW-1:0]);
        wr_idx_next = wr_idx + CW'(1);
      end
      if (sts.rm_done) count_next = wr_idx;
    end

    if (cmd.dump_run) begin
      if (issue) begin
        rd_en        = 1'b1;
        rd_addr      = phys(head, idx[PW-1:0]);
        idx_next     = idx + CW'(1);
        rd_last_next = ((idx + CW'(1)) == count);
      end
      rd_valid_next = issue || (rd_valid && !ent_load);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      idx       <= '0;
      wr_idx    <= '0;
      cmp_valid <= 1'b0;
      rd_valid  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      head      <= head_next;
      count     <= count_next;
      idx       <= idx_next;
      wr_idx    <= wr_idx_next;
      cmp_valid <= cmp_valid_next;
      rd_valid  <= rd_valid_next;
      if (status_load || ent_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_last <= rd_last_next;
    if (cmd.accept) begin
      key <= operand;
      ovf <= is_push && full;
    end
    if (status_load) begin
      out_entry <= '0;
      out_last  <= 1'b1;
      out_empty <= (count == '0);
      out_ovf   <= ovf;
      out_count <= count_x[COUNT_W-1:0];
    end else if (ent_load) begin
      out_entry <= rdata;
      out_last  <= rd_last;
      out_empty <= 1'b0;
      out_ovf   <= 1'b0;
      out_count <= count_x[COUNT_W-1:0];
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= DEPTH_C, "count above depth")
  `ASSERT_ALWAYS(a_wr_behind_rd, clk, rst, wr_idx <= idx, "write pointer passed read pointer")
  `ASSERT_PROP(a_rdv_dump, clk, rst, (rd_valid |-> cmd.dump_run), "read data pending outside dump")
  `ASSERT_PROP(a_rm_shrinks, clk, rst, ((cmd.rm_run && sts.rm_done) |=> (count <= $past(count))), "remove grew the list")

endmodule
